FILE: design/rvu_pkg.sv
// Package for the refraction vector unit: fixed-point widths, beat types and
// the saturation helper. No dependencies.
`default_nettype none
package rvu_pkg;
	localparam int FRAC_BITS = 14;
	localparam int ETA_W = 16;
	localparam int V_W = 16;
	localparam int C_W = 15;
	localparam int C2_W = 2 * C_W - FRAC_BITS;
	localparam int E2_W = 2 * ETA_W - FRAC_BITS;
	localparam int D_W = ((C2_W > FRAC_BITS + 1) ? C2_W : FRAC_BITS + 1) + 1;
	localparam int P_W = E2_W + 1 + D_W;
	localparam int K_W = P_W - FRAC_BITS + 1;
	localparam int S_W = (K_W - 1 + FRAC_BITS + 1) / 2;
	localparam int RAD_W = 2 * S_W;
	localparam int REM_W = S_W + 2;
	localparam int EC_W = ETA_W + C_W - FRAC_BITS;
	localparam int M_W = ((EC_W > S_W) ? EC_W : S_W) + 1;
	localparam int EVI_W = ETA_W + 1 + V_W - FRAC_BITS;
	localparam int MP_W = C_W + 2 + V_W - FRAC_BITS;
	localparam int MN_W = M_W + V_W - FRAC_BITS;
	localparam int SAT_W = MN_W + 2;
	localparam logic [ETA_W-1:0] ETA_ONE = ETA_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [ETA_W-1:0] index_ratio;
		logic signed [V_W-1:0] incident_x;
		logic signed [V_W-1:0] incident_y;
		logic signed [V_W-1:0] incident_z;
		logic signed [V_W-1:0] normal_x;
		logic signed [V_W-1:0] normal_y;
		logic signed [V_W-1:0] normal_z;
		logic [C_W-1:0] cosine_in;
	} in_beat_t;

	typedef struct packed {
		logic signed [V_W-1:0] out_x;
		logic signed [V_W-1:0] out_y;
		logic signed [V_W-1:0] out_z;
		logic transmitted;
	} out_beat_t;

	// Everything the square root and back end need from the front end.
	typedef struct packed {
		logic bypass;
		logic transmitted;
		logic [RAD_W-1:0] rad;
		logic [EC_W-1:0] ec;
		logic [2:0][EVI_W-1:0] evi;
		logic [2:0][V_W-1:0] vn;
		logic [2:0][V_W-1:0] alt;
	} front_t;

	typedef struct packed {
		front_t f;
		logic [REM_W-1:0] rem;
		logic [S_W-1:0] root;
	} sq_t;

	function automatic logic [V_W-1:0] sat_v(input logic [SAT_W-1:0] v);
		logic [SAT_W-V_W:0] hi;
		begin
			hi = v[SAT_W-1:V_W-1];
			if ((&hi) || !(|hi))
				return v[V_W-1:0];
			else if (v[SAT_W-1])
				return {1'b1, {(V_W-1){1'b0}}};
			else
				return {1'b0, {(V_W-1){1'b1}}};
		end
	endfunction
endpackage
`default_nettype wire

FILE: design/rvu_if.sv
// Valid/ready channel interfaces for the refraction vector unit.
// Depends on rvu_pkg for the beat types.
`default_nettype none
interface rvu_in_if;
	logic valid;
	logic ready;
	rvu_pkg::in_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rvu_out_if;
	logic valid;
	logic ready;
	rvu_pkg::out_beat_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/refraction_vector_unit.sv
// Top level of the refraction vector unit: front end, square root, back end.
// Depends on rvu_pkg, rvu_if, rvu_front, rvu_sqrt and rvu_back.
//
// The unit takes one ray hit per cycle unless backpressure fills the pipeline,
// and returns its refracted direction, or the mirror direction with transmitted
// low on total internal reflection, through three front-end stages, one
// square-root stage per result bit (18 with the default 14 fraction bits) and
// three back-end stages. Every stage holds its beat under backpressure, so
// bubbles fill while the output waits.
`default_nettype none
module refraction_vector_unit (
	input wire logic clk,
	input wire logic arst_n,
	rvu_in_if.sink req,
	rvu_out_if.source rsp
);
	import rvu_pkg::*;

	logic f_valid, f_ready, q_valid, q_ready;
	front_t f_data;
	sq_t q_data;

	rvu_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.ds_valid(f_valid), .ds_ready(f_ready), .ds_data(f_data)
	);

	rvu_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n),
		.us_valid(f_valid), .us_ready(f_ready), .us_data(f_data),
		.ds_valid(q_valid), .ds_ready(q_ready), .ds_data(q_data)
	);

	rvu_back u_back (
		.clk(clk), .arst_n(arst_n),
		.us_valid(q_valid), .us_ready(q_ready), .us_data(q_data),
		.rsp(rsp)
	);
endmodule
`default_nettype wire

FILE: design/rvu_front.sv
// Front end: three stages of products, k = 1 - eta^2(1 - c^2), mirror vector.
// Depends on rvu_pkg and rvu_if.
`default_nettype none
module rvu_front (
	input wire logic clk,
	input wire logic arst_n,
	rvu_in_if.sink req,
	output logic ds_valid,
	input wire logic ds_ready,
	output rvu_pkg::front_t ds_data
);
	import rvu_pkg::*;

	typedef struct packed {
		logic pass;
		logic [C2_W-1:0] c2;
		logic [E2_W-1:0] e2;
		logic [EC_W-1:0] ec;
		logic [2:0][EVI_W-1:0] evi;
		logic [2:0][MP_W-1:0] mp;
		logic [2:0][V_W-1:0] vi;
		logic [2:0][V_W-1:0] vn;
	} st1_t;

	typedef struct packed {
		logic pass;
		logic [P_W-1:0] p;
		logic [EC_W-1:0] ec;
		logic [2:0][EVI_W-1:0] evi;
		logic [2:0][V_W-1:0] vn;
		logic [2:0][V_W-1:0] alt;
	} st2_t;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	st1_t d_s1, n1;
	st2_t d_s2, n2;
	front_t d_s3, n3;

	assign rdy3 = !v_s3 || ds_ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign req.ready = rdy1;
	assign ds_valid = v_s3;
	assign ds_data = d_s3;

	always_comb begin
		logic [2*C_W-1:0] cc;
		logic [2*ETA_W-1:0] ee;
		logic [ETA_W+C_W-1:0] ecp;
		logic signed [ETA_W+V_W:0] pv;
		logic signed [C_W+1+V_W:0] pm;
		logic [2:0][V_W-1:0] vi, vn;
		vi = {req.data.incident_z, req.data.incident_y, req.data.incident_x};
		vn = {req.data.normal_z, req.data.normal_y, req.data.normal_x};
		cc = C_W'(req.data.cosine_in) * C_W'(req.data.cosine_in);
		ee = ETA_W'(req.data.index_ratio) * ETA_W'(req.data.index_ratio);
		ecp = (ETA_W+C_W)'(req.data.index_ratio) * (ETA_W+C_W)'(req.data.cosine_in);
		n1.pass = (req.data.index_ratio == ETA_ONE);
		n1.c2 = cc[2*C_W-1:FRAC_BITS];
		n1.e2 = ee[2*ETA_W-1:FRAC_BITS];
		n1.ec = ecp[ETA_W+C_W-1:FRAC_BITS];
		n1.vi = vi;
		n1.vn = vn;
		for (int j = 0; j < 3; j++) begin
			pv = $signed({1'b0, req.data.index_ratio}) * $signed(vi[j]);
			pm = $signed({2'b00, req.data.cosine_in, 1'b0}) * $signed(vn[j]);
			n1.evi[j] = pv[ETA_W+V_W:FRAC_BITS];
			n1.mp[j] = pm[C_W+1+V_W:FRAC_BITS];
		end
	end

	always_comb begin
		logic signed [D_W-1:0] d;
		logic signed [MP_W:0] ms;
		logic [SAT_W-1:0] mw;
		d = $signed(D_W'(ETA_ONE)) - $signed(D_W'(d_s1.c2));
		n2.pass = d_s1.pass;
		n2.p = $signed({1'b0, d_s1.e2}) * d;
		n2.ec = d_s1.ec;
		n2.evi = d_s1.evi;
		n2.vn = d_s1.vn;
		for (int j = 0; j < 3; j++) begin
			ms = $signed((MP_W+1)'($signed(d_s1.mp[j])))
				+ $signed((MP_W+1)'($signed(d_s1.vi[j])));
			mw = SAT_W'(ms);
			n2.alt[j] = d_s1.pass ? d_s1.vi[j] : sat_v(mw);
		end
	end

	always_comb begin
		logic signed [K_W-1:0] k;
		logic [P_W-FRAC_BITS-1:0] q;
		q = d_s2.p[P_W-1:FRAC_BITS];
		k = $signed(K_W'(ETA_ONE)) - $signed(K_W'($signed(q)));
		n3.bypass = d_s2.pass || k[K_W-1];
		n3.transmitted = d_s2.pass || !k[K_W-1];
		n3.rad = RAD_W'({k[K_W-2:0], {FRAC_BITS{1'b0}}});
		n3.ec = d_s2.ec;
		n3.evi = d_s2.evi;
		n3.vn = d_s2.vn;
		n3.alt = d_s2.alt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= req.valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && req.valid) d_s1 <= n1;
		if (rdy2 && v_s1) d_s2 <= n2;
		if (rdy3 && v_s2) d_s3 <= n3;
	end
endmodule
`default_nettype wire

FILE: design/rvu_sqrt.sv
// Square root of k, one result bit per pipeline stage, restoring method.
// Depends on rvu_pkg.
`default_nettype none
module rvu_sqrt (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic us_valid,
	output logic us_ready,
	input wire rvu_pkg::front_t us_data,
	output logic ds_valid,
	input wire logic ds_ready,
	output rvu_pkg::sq_t ds_data
);
	import rvu_pkg::*;

	logic [S_W:0] v_q;
	logic [S_W:0] rdy;
	sq_t d_q [S_W+1];

	assign v_q[0] = us_valid;
	assign us_ready = rdy[0];
	assign rdy[S_W] = ds_ready;
	assign ds_valid = v_q[S_W];
	assign ds_data = d_q[S_W];

	always_comb begin
		d_q[0].f = us_data;
		d_q[0].rem = '0;
		d_q[0].root = '0;
	end

	for (genvar i = 0; i < S_W; i++) begin : g_step
		sq_t nx;
		logic [REM_W-1:0] r2, trial;
		assign rdy[i] = !v_q[i+1] || rdy[i+1];

		always_comb begin
			nx = d_q[i];
			r2 = {d_q[i].rem[REM_W-3:0], d_q[i].f.rad[RAD_W-1:RAD_W-2]};
			trial = {d_q[i].root, 2'b01};
			nx.f.rad = {d_q[i].f.rad[RAD_W-3:0], 2'b00};
			if (r2 >= trial) begin
				nx.rem = r2 - trial;
				nx.root = {d_q[i].root[S_W-2:0], 1'b1};
			end else begin
				nx.rem = r2;
				nx.root = {d_q[i].root[S_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else if (rdy[i]) begin
				v_q[i+1] <= v_q[i];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[i] && v_q[i]) d_q[i+1] <= nx;
		end
	end
endmodule
`default_nettype wire

FILE: design/rvu_back.sv
// Back end: m = eta*c - sqrt(k), m*N, final sum, saturation and select.
// Depends on rvu_pkg and rvu_if.
`default_nettype none
module rvu_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic us_valid,
	output logic us_ready,
	input wire rvu_pkg::sq_t us_data,
	rvu_out_if.source rsp
);
	import rvu_pkg::*;

	typedef struct packed {
		logic bypass;
		logic transmitted;
		logic [M_W-1:0] m;
		logic [2:0][EVI_W-1:0] evi;
		logic [2:0][V_W-1:0] vn;
		logic [2:0][V_W-1:0] alt;
	} stb1_t;

	typedef struct packed {
		logic bypass;
		logic transmitted;
		logic [2:0][MN_W-1:0] mn;
		logic [2:0][EVI_W-1:0] evi;
		logic [2:0][V_W-1:0] alt;
	} stb2_t;

	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;
	stb1_t d_s1, n1;
	stb2_t d_s2, n2;
	out_beat_t d_s3, n3;

	assign rdy3 = !v_s3 || rsp.ready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign us_ready = rdy1;
	assign rsp.valid = v_s3;
	assign rsp.data = d_s3;

	always_comb begin
		n1.bypass = us_data.f.bypass;
		n1.transmitted = us_data.f.transmitted;
		n1.m = M_W'(us_data.f.ec) - M_W'(us_data.root);
		n1.evi = us_data.f.evi;
		n1.vn = us_data.f.vn;
		n1.alt = us_data.f.alt;
	end

	always_comb begin
		logic signed [M_W+V_W-1:0] p;
		n2.bypass = d_s1.bypass;
		n2.transmitted = d_s1.transmitted;
		n2.evi = d_s1.evi;
		n2.alt = d_s1.alt;
		for (int j = 0; j < 3; j++) begin
			p = $signed(d_s1.m) * $signed(d_s1.vn[j]);
			n2.mn[j] = p[M_W+V_W-1:FRAC_BITS];
		end
	end

	always_comb begin
		logic [2:0][V_W-1:0] r;
		logic signed [SAT_W-1:0] s;
		for (int j = 0; j < 3; j++) begin
			s = $signed(SAT_W'($signed(d_s2.evi[j]))) + $signed(SAT_W'($signed(d_s2.mn[j])));
			r[j] = d_s2.bypass ? d_s2.alt[j] : sat_v(s);
		end
		n3.out_x = r[0];
		n3.out_y = r[1];
		n3.out_z = r[2];
		n3.transmitted = d_s2.transmitted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= us_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && us_valid) d_s1 <= n1;
		if (rdy2 && v_s1) d_s2 <= n2;
		if (rdy3 && v_s2) d_s3 <= n3;
	end
endmodule
`default_nettype wire
